/* hdl/apcm_pkg.sv */
// Shared types, constants and state codes of the atom pair contact map.
`timescale 1ns / 1ps
`default_nettype none
package apcm_pkg;

  // Field widths
  localparam int COORD_W = 20;
  localparam int CUT_W   = 21;
  localparam int MAG_W   = 21;
  localparam int SQ_W    = 42;
  localparam int ROOT_W  = 21;
  localparam int IDX_W   = 16;
  localparam int TOT_W   = 17;

  // Frame capacity and the counter limits that follow from it
  localparam int MAX_PAIRS = 65536;
  localparam int IDX_CAP   = (MAX_PAIRS - 1 > 65535) ? 65535 : MAX_PAIRS - 1;
  localparam int CNT_CAP   = (MAX_PAIRS > 131071) ? 131071 : MAX_PAIRS;

  // Radix-4 serial squaring: two multiplier bits per step
  localparam int SQ_STEPS = (MAG_W + 1) / 2;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS);

  // Integer square root: one result bit per step
  localparam int ISQ_BIT_W = SQ_W + 1;
  localparam int ISQ_RES_W = SQ_W + 2;

  localparam logic signed [CUT_W-1:0] CUTOFF_RST = CUT_W'(900);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_DECIDE,
    ST_ROOT,
    ST_ENTRY,
    ST_COUNT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic                      frame_end;
  } in_beat_t;

  typedef struct packed {
    logic              is_count;
    logic [IDX_W-1:0]  pair_index;
    logic [ROOT_W-1:0] entry_value;
    logic [TOT_W-1:0]  entry_total;
    logic              last;
  } out_beat_t;

  // Handshake between the sequencer and the root unit
  typedef struct packed {
    logic start;
  } isq_ctl_t;

  typedef struct packed {
    logic done;
  } isq_sts_t;

endpackage
`default_nettype wire

/* hdl/apcm_sq_lane.sv */
// Radix-4 serial squarer: one multiplier digit of two bits per step.
`timescale 1ns / 1ps
`default_nettype none
module apcm_sq_lane (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic                        step,
  input  wire logic [apcm_pkg::MAG_W-1:0]  mag,
  output logic      [apcm_pkg::SQ_W-1:0]   square
);

  logic [apcm_pkg::MAG_W-1:0] mplier_r, mplier_nxt;
  logic [apcm_pkg::SQ_W-1:0]  mcand_r, mcand_nxt;
  logic [apcm_pkg::SQ_W-1:0]  acc_r, acc_nxt;
  logic [apcm_pkg::SQ_W-1:0]  pp;

  // Form the partial product of the low digit
  always_comb begin
    pp = (mplier_r[0] ? mcand_r : '0) + (mplier_r[1] ? {mcand_r[apcm_pkg::SQ_W-2:0], 1'b0} : '0);
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    if (load) begin
      mplier_nxt = mag;
      mcand_nxt  = {{(apcm_pkg::SQ_W - apcm_pkg::MAG_W){1'b0}}, mag};
      acc_nxt    = '0;
    end else if (step) begin
      mplier_nxt = {2'b00, mplier_r[apcm_pkg::MAG_W-1:2]};
      mcand_nxt  = {mcand_r[apcm_pkg::SQ_W-3:0], 2'b00};
      acc_nxt    = acc_r + pp;
    end
  end

  // Advance the digit registers
  always_ff @(posedge clk) begin
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
  end

  assign square = acc_r;

endmodule
`default_nettype wire

/* hdl/apcm_isqrt.sv */
// Bit-serial integer square root of the squared distance.
`timescale 1ns / 1ps
`default_nettype none
module apcm_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire apcm_pkg::isq_ctl_t           ctl,
  input  wire logic [apcm_pkg::SQ_W-1:0]    radicand,
  output apcm_pkg::isq_sts_t                sts,
  output logic      [apcm_pkg::ROOT_W-1:0]  root
);

  logic [apcm_pkg::ISQ_RES_W-1:0] rem_r, rem_nxt;
  logic [apcm_pkg::ISQ_RES_W-1:0] res_r, res_nxt;
  logic [apcm_pkg::ISQ_BIT_W-1:0] bit_r, bit_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [apcm_pkg::ISQ_RES_W-1:0] trial;

  // Try one result bit per step
  always_comb begin
    trial    = res_r + apcm_pkg::ISQ_RES_W'(bit_r);
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = apcm_pkg::ISQ_RES_W'(radicand);
      res_nxt  = '0;
      bit_nxt  = {1'b1, {(apcm_pkg::ISQ_BIT_W - 1){1'b0}}};
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + apcm_pkg::ISQ_RES_W'(bit_r);
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold the datapath, reset the control
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.done = done_r;
  assign root     = res_r[apcm_pkg::ROOT_W-1:0];

`ifndef NO_ASSERTIONS
  // A finished root leaves the unit idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("root done while busy");
  // A started root is busy next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r) else $error("root unit not busy after start");
  // The running bit is one-hot while busy
  a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot(bit_r)) else $error("root bit not one-hot");
`endif

endmodule
`default_nettype wire

/* hdl/atom_pair_contact_map.sv */
// Top level of the atom pair contact map: sequencer, counters and output register.
// Contact mode (positive cutoff): an accepted item passes the radix-4 serial squarers, the sum
//   and the decision on its way to its entry beat; no new item is taken before it is done.
// Distance mode: a nonzero distance also passes the bit-serial square root before its entry.
// A pair with no entry frees the input after the decision; a frame end adds a count beat.
// Reset (synchronous, rst_n low) clears both counters and sets the cutoff to 900.
`timescale 1ns / 1ps
`default_nettype none
module atom_pair_contact_map (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire apcm_pkg::in_beat_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output apcm_pkg::out_beat_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic signed [apcm_pkg::CUT_W-1:0]    cfg_data
);

  apcm_pkg::state_t state_r, state_nxt;

  logic signed [apcm_pkg::CUT_W-1:0]    cutoff_r;
  logic [apcm_pkg::IDX_W-1:0]           pair_cnt_r;
  logic [apcm_pkg::TOT_W-1:0]           nz_cnt_r;
  logic [apcm_pkg::SQ_CNT_W-1:0]        sq_cnt_r;
  logic [apcm_pkg::IDX_W-1:0]           idx_r;
  logic                                 fend_r;
  logic [apcm_pkg::SQ_W-1:0]            sum_r;
  logic [apcm_pkg::ROOT_W-1:0]          value_r;
  logic                                 out_valid_r;
  apcm_pkg::out_beat_t                  out_data_r;

  logic                                 accept;
  logic                                 out_free;
  logic                                 cut_pos;
  logic                                 sq_step;
  logic                                 load_entry;
  logic                                 load_count;
  apcm_pkg::isq_ctl_t                   isq_ctl;
  apcm_pkg::isq_sts_t                   isq_sts;
  logic [apcm_pkg::ROOT_W-1:0]          root;
  logic [apcm_pkg::MAG_W-1:0]           mag_x, mag_y, mag_z, mag_c;
  logic signed [apcm_pkg::MAG_W-1:0]    dx, dy, dz;
  logic [apcm_pkg::SQ_W-1:0]            sq_x, sq_y, sq_z, sq_c;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cut_pos   = !cutoff_r[apcm_pkg::CUT_W-1] && (cutoff_r != '0);
  assign cfg_ready = rst_n;

  // Form the coordinate differences and their magnitudes
  always_comb begin
    dx = apcm_pkg::MAG_W'(in_data.first_x) - apcm_pkg::MAG_W'(in_data.second_x);
    dy = apcm_pkg::MAG_W'(in_data.first_y) - apcm_pkg::MAG_W'(in_data.second_y);
    dz = apcm_pkg::MAG_W'(in_data.first_z) - apcm_pkg::MAG_W'(in_data.second_z);
    mag_x = dx[apcm_pkg::MAG_W-1] ? apcm_pkg::MAG_W'(-dx) : apcm_pkg::MAG_W'(dx);
    mag_y = dy[apcm_pkg::MAG_W-1] ? apcm_pkg::MAG_W'(-dy) : apcm_pkg::MAG_W'(dy);
    mag_z = dz[apcm_pkg::MAG_W-1] ? apcm_pkg::MAG_W'(-dz) : apcm_pkg::MAG_W'(dz);
    mag_c = {1'b0, cutoff_r[apcm_pkg::CUT_W-2:0]};
  end

  // Square the three axes and the cutoff side by side
  apcm_sq_lane u_sq_x (.clk(clk), .load(accept), .step(sq_step), .mag(mag_x), .square(sq_x));
  apcm_sq_lane u_sq_y (.clk(clk), .load(accept), .step(sq_step), .mag(mag_y), .square(sq_y));
  apcm_sq_lane u_sq_z (.clk(clk), .load(accept), .step(sq_step), .mag(mag_z), .square(sq_z));
  apcm_sq_lane u_sq_c (.clk(clk), .load(accept), .step(sq_step), .mag(mag_c), .square(sq_c));

  apcm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (isq_ctl),
    .radicand (sum_r),
    .sts      (isq_sts),
    .root     (root)
  );

  // Sequence one item through squaring, decision, root and output
  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    sq_step       = 1'b0;
    load_entry    = 1'b0;
    load_count    = 1'b0;
    isq_ctl.start = 1'b0;
    case (state_r)
      apcm_pkg::ST_IDLE: begin
        in_stall = !rst_n;
        if (in_valid) state_nxt = apcm_pkg::ST_SQUARE;
      end
      apcm_pkg::ST_SQUARE: begin
        sq_step = 1'b1;
        if (sq_cnt_r == apcm_pkg::SQ_CNT_W'(apcm_pkg::SQ_STEPS - 1)) begin
          state_nxt = apcm_pkg::ST_SUM;
        end
      end
      apcm_pkg::ST_SUM: begin
        state_nxt = apcm_pkg::ST_DECIDE;
      end
      apcm_pkg::ST_DECIDE: begin
        if (cut_pos) begin
          if (sum_r < sq_c) state_nxt = apcm_pkg::ST_ENTRY;
          else if (fend_r) state_nxt = apcm_pkg::ST_COUNT;
          else state_nxt = apcm_pkg::ST_IDLE;
        end else if (sum_r != '0) begin
          isq_ctl.start = 1'b1;
          state_nxt     = apcm_pkg::ST_ROOT;
        end else if (fend_r) begin
          state_nxt = apcm_pkg::ST_COUNT;
        end else begin
          state_nxt = apcm_pkg::ST_IDLE;
        end
      end
      apcm_pkg::ST_ROOT: begin
        if (isq_sts.done) state_nxt = apcm_pkg::ST_ENTRY;
      end
      apcm_pkg::ST_ENTRY: begin
        if (out_free) begin
          load_entry = 1'b1;
          state_nxt  = fend_r ? apcm_pkg::ST_COUNT : apcm_pkg::ST_IDLE;
        end
      end
      apcm_pkg::ST_COUNT: begin
        if (out_free) begin
          load_count = 1'b1;
          state_nxt  = apcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = apcm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apcm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the cutoff, the counters and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= apcm_pkg::CUTOFF_RST;
      pair_cnt_r  <= '0;
      nz_cnt_r    <= '0;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cutoff_r <= cfg_data;
      if (accept) begin
        sq_cnt_r <= '0;
        if (pair_cnt_r < apcm_pkg::IDX_W'(apcm_pkg::IDX_CAP)) pair_cnt_r <= pair_cnt_r + 1'b1;
      end else if (sq_step) begin
        sq_cnt_r <= sq_cnt_r + 1'b1;
      end
      if (load_entry && (nz_cnt_r < apcm_pkg::TOT_W'(apcm_pkg::CNT_CAP))) begin
        nz_cnt_r <= nz_cnt_r + 1'b1;
      end
      if (load_count) begin
        pair_cnt_r <= '0;
        nz_cnt_r   <= '0;
      end
      if (load_entry || load_count) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Capture item data, the sum, the entry value and the outgoing beat
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= pair_cnt_r;
      fend_r <= in_data.frame_end;
    end
    if (state_r == apcm_pkg::ST_SUM) sum_r <= sq_x + sq_y + sq_z;
    if (state_r == apcm_pkg::ST_DECIDE) value_r <= apcm_pkg::ROOT_W'(1);
    else if (isq_sts.done) value_r <= root;
    if (load_entry) begin
      out_data_r.is_count    <= 1'b0;
      out_data_r.pair_index  <= idx_r;
      out_data_r.entry_value <= value_r;
      out_data_r.entry_total <= '0;
      out_data_r.last        <= !fend_r;
    end else if (load_count) begin
      out_data_r.is_count    <= 1'b1;
      out_data_r.pair_index  <= '0;
      out_data_r.entry_value <= '0;
      out_data_r.entry_total <= nz_cnt_r;
      out_data_r.last        <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // An accepted beat starts the squarers
  a_accept_square: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == apcm_pkg::ST_SQUARE) else $error("accept did not start squaring");
  // The pair index never passes its cap
  a_idx_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pair_cnt_r <= apcm_pkg::IDX_W'(apcm_pkg::IDX_CAP)) else $error("pair index above cap");
  // A count beat clears both counters
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_count |=> (pair_cnt_r == '0) && (nz_cnt_r == '0)) else $error("counters not cleared");
  // A root result only arrives while waiting for it
  a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    isq_sts.done |-> state_r == apcm_pkg::ST_ROOT) else $error("root done outside root wait");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the atom pair contact map: directed table and random phases.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int CMIN          = -524288;
  localparam int CMAX          = 524287;
  localparam int SETTLE_CYCLES = 60;
  localparam int WATCHDOG      = 4000;
  localparam int PHASE_PAIRS   = 234;

  // One row of the directed table: a cutoff write or a pair with optional typed results
  typedef struct {
    bit                  do_cfg;
    int                  cut;
    apcm_pkg::in_beat_t  item;
    int                  n_typed;
    apcm_pkg::out_beat_t rec0;
    apcm_pkg::out_beat_t rec1;
  } dir_row_t;

  localparam apcm_pkg::out_beat_t NO_REC = '0;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  apcm_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  apcm_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic signed [apcm_pkg::CUT_W-1:0] cfg_data = '0;

  // Predictor state
  logic signed [apcm_pkg::CUT_W-1:0] cutoff_q;
  logic [apcm_pkg::TOT_W-1:0]        pair_cnt;
  logic [apcm_pkg::TOT_W-1:0]        hit_cnt;
  apcm_pkg::out_beat_t               expected_q[$];

  // Typed results for the pair on the input channel; -1 selects the predictor
  int                  typed_n = -1;
  apcm_pkg::out_beat_t typed_rec [2];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  atom_pair_contact_map dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Squared difference along one axis
  function automatic longint unsigned axis_sq(logic signed [apcm_pkg::COORD_W-1:0] a,
                                              logic signed [apcm_pkg::COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  // Floor square root, one result bit at a time from the top
  function automatic logic [apcm_pkg::ROOT_W-1:0] floor_root(longint unsigned s);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = apcm_pkg::ROOT_W; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r[apcm_pkg::ROOT_W-1:0];
  endfunction

  // Work out the result beats of one pair and advance the frame counters
  task automatic model_pair(input apcm_pkg::in_beat_t b, output apcm_pkg::out_beat_t rec [2],
                            output int n);
    longint unsigned             sq;
    longint unsigned             lim;
    logic                        hit;
    logic [apcm_pkg::ROOT_W-1:0] val;
    logic [apcm_pkg::IDX_W-1:0]  idx;
    sq = axis_sq(b.first_x, b.second_x) + axis_sq(b.first_y, b.second_y) +
         axis_sq(b.first_z, b.second_z);
    hit = 1'b0;
    val = '0;
    idx = pair_cnt[apcm_pkg::IDX_W-1:0];
    n = 0;
    rec[0] = NO_REC;
    rec[1] = NO_REC;
    if (cutoff_q > 0) begin
      lim = longint'(cutoff_q);
      lim = lim * lim;
      if (sq < lim) begin
        hit = 1'b1;
        val = apcm_pkg::ROOT_W'(1);
      end
    end else if (sq != 0) begin
      hit = 1'b1;
      val = floor_root(sq);
    end
    if (pair_cnt < apcm_pkg::IDX_CAP) pair_cnt++;
    if (hit) begin
      if (hit_cnt < apcm_pkg::CNT_CAP) hit_cnt++;
      rec[0].pair_index  = idx;
      rec[0].entry_value = val;
      rec[0].last        = !b.frame_end;
      n = 1;
    end
    if (b.frame_end) begin
      rec[n].is_count    = 1'b1;
      rec[n].entry_total = hit_cnt;
      rec[n].last        = 1'b1;
      n++;
      pair_cnt = '0;
      hit_cnt  = '0;
    end
  endtask

  // Track handshakes: predict on input beats, check output beats, watch for a hang
  always @(posedge clk) begin
    apcm_pkg::out_beat_t pred [2];
    apcm_pkg::out_beat_t want;
    int                  n;
    if (!rst_n) begin
      cutoff_q = apcm_pkg::CUTOFF_RST;
      pair_cnt = '0;
      hit_cnt  = '0;
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) cutoff_q = cfg_data;
      if (in_valid && !in_stall) begin
        model_pair(in_data, pred, n);
        if (typed_n >= 0) begin
          for (int i = 0; i < typed_n; i++) expected_q.insert(expected_q.size(), typed_rec[i]);
        end else begin
          for (int i = 0; i < n; i++) expected_q.insert(expected_q.size(), pred[i]);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.is_count !== want.is_count) begin
            $error("is_count mismatch: expected %0d, actual %0d",
                   want.is_count, out_data.is_count);
            errors++;
          end
          if (out_data.pair_index !== want.pair_index) begin
            $error("pair_index mismatch: expected %0d, actual %0d",
                   want.pair_index, out_data.pair_index);
            errors++;
          end
          if (out_data.entry_value !== want.entry_value) begin
            $error("entry_value mismatch: expected %0d, actual %0d",
                   want.entry_value, out_data.entry_value);
            errors++;
          end
          if (out_data.entry_total !== want.entry_total) begin
            $error("entry_total mismatch: expected %0d, actual %0d",
                   want.entry_total, out_data.entry_total);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_data.last);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < sink_stall_pct);
  end

  function automatic apcm_pkg::in_beat_t pair(int fx, int fy, int fz, int sx, int sy, int sz,
                                              bit fe);
    apcm_pkg::in_beat_t b;
    b.first_x   = apcm_pkg::COORD_W'(fx);
    b.first_y   = apcm_pkg::COORD_W'(fy);
    b.first_z   = apcm_pkg::COORD_W'(fz);
    b.second_x  = apcm_pkg::COORD_W'(sx);
    b.second_y  = apcm_pkg::COORD_W'(sy);
    b.second_z  = apcm_pkg::COORD_W'(sz);
    b.frame_end = fe;
    return b;
  endfunction

  function automatic apcm_pkg::out_beat_t entry_rec(int idx, int val, bit lst);
    apcm_pkg::out_beat_t r;
    r = NO_REC;
    r.pair_index  = apcm_pkg::IDX_W'(idx);
    r.entry_value = apcm_pkg::ROOT_W'(val);
    r.last        = lst;
    return r;
  endfunction

  function automatic apcm_pkg::out_beat_t count_rec(int total);
    apcm_pkg::out_beat_t r;
    r = NO_REC;
    r.is_count    = 1'b1;
    r.entry_total = apcm_pkg::TOT_W'(total);
    r.last        = 1'b1;
    return r;
  endfunction

  // Full-range coordinate with the extremes weighted in
  function automatic logic signed [apcm_pkg::COORD_W-1:0] any_coord();
    case ($urandom_range(7))
      0:       return apcm_pkg::COORD_W'(CMIN);
      1:       return apcm_pkg::COORD_W'(CMAX);
      default: return apcm_pkg::COORD_W'($urandom);
    endcase
  endfunction

  // Move a coordinate by up to span steps either way, mirroring the step if it leaves the range
  function automatic logic signed [apcm_pkg::COORD_W-1:0] nudge(
      logic signed [apcm_pkg::COORD_W-1:0] c, int span);
    int off;
    int v;
    off = int'($urandom_range(2 * span)) - span;
    v = int'(c) + off;
    if (v > CMAX || v < CMIN) v = int'(c) - off;
    return apcm_pkg::COORD_W'(v);
  endfunction

  // Mostly near pairs so that both sides of the cutoff are hit, some far and some coincident
  function automatic apcm_pkg::in_beat_t rand_pair(int reach);
    apcm_pkg::in_beat_t b;
    int                 kind;
    int                 span;
    kind = $urandom_range(9);
    span = $urandom_range(reach);
    b.first_x   = any_coord();
    b.first_y   = any_coord();
    b.first_z   = any_coord();
    b.frame_end = ($urandom_range(7) == 0);
    if (kind < 3) begin
      b.second_x = any_coord();
      b.second_y = any_coord();
      b.second_z = any_coord();
    end else if (kind < 9) begin
      b.second_x = nudge(b.first_x, span);
      b.second_y = nudge(b.first_y, span);
      b.second_z = nudge(b.first_z, span);
    end else begin
      b.second_x = b.first_x;
      b.second_y = b.first_y;
      b.second_z = b.first_z;
    end
    return b;
  endfunction

  // Present one pair and hold it until the block takes it
  task automatic send_pair(input apcm_pkg::in_beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected beat, then let the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cutoff(input logic signed [apcm_pkg::CUT_W-1:0] v);
    settle();
    cfg_data  = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    dir_row_t           dir_tab[$];
    int                 cut_plan [8];
    int                 idle_plan [4][2];
    int                 reach;
    apcm_pkg::in_beat_t b;

    // Contact mode at the reset cutoff of 900
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(0, 0, 0, 0, 0, 0, 0), 1,
                                     entry_rec(0, 1, 1), NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(899, 0, 0, 0, 0, 0, 0), 1,
                                     entry_rec(1, 1, 1), NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(0, 900, 0, 0, 0, 0, 0), 0, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1), 1,
                                     count_rec(2), NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1), 1,
                                     count_rec(0), NO_REC});
    // Distance mode at zero cutoff
    dir_tab.insert(dir_tab.size(), '{1, 0, '0, 0, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(0, 0, 0, 0, 0, 0, 0), 0, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(3, 4, 0, 0, 0, 0, 0), 1,
                                     entry_rec(1, 5, 1), NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0), 1,
                                     entry_rec(2, 1816185, 1), NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(-7, 100, -3000, 12, -5, 77, 1), -1,
                                     NO_REC, NO_REC});
    // Distance mode at the most negative cutoff
    dir_tab.insert(dir_tab.size(), '{1, -1048576, '0, 0, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(1, 1, 1, 0, 0, 0, 1), 2,
                                     entry_rec(0, 1, 0), count_rec(1)});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(123456, -234567, 345678, -456789, 0, 1, 0),
                                     -1, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(0, 0, 0, 0, 0, 0, 1), 1,
                                     count_rec(1), NO_REC});
    dir_tab.insert(dir_tab.size(), '{1, -1, '0, 0, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(1000, 0, 0, 0, 0, 0, 1), 2,
                                     entry_rec(0, 1000, 0), count_rec(1)});
    // Largest cutoff: a pair exactly at the cutoff stays out
    dir_tab.insert(dir_tab.size(), '{1, 1048575, '0, 0, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(CMAX, 0, 0, CMIN, 0, 0, 0), 0,
                                     NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(CMAX - 1, 0, 0, CMIN, 0, 0, 0), 1,
                                     entry_rec(1, 1, 1), NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(0, 0, 0, CMIN, CMIN, CMIN, 1), -1,
                                     NO_REC, NO_REC});
    // Smallest cutoff: only coincident atoms are in contact
    dir_tab.insert(dir_tab.size(), '{1, 1, '0, 0, NO_REC, NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(5, 5, 5, 5, 5, 5, 0), 1,
                                     entry_rec(0, 1, 1), NO_REC});
    dir_tab.insert(dir_tab.size(), '{0, 0, pair(5, 5, 5, 5, 5, 6, 1), 1,
                                     count_rec(1), NO_REC});

    cut_plan  = '{900, 1048575, 1, 0, -1048576, -1, 0, 0};
    idle_plan = '{'{0, 0}, '{85, 0}, '{0, 85}, '{31, 31}};

    // Hold reset, then release on a falling edge
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table with no idling
    foreach (dir_tab[i]) begin
      if (dir_tab[i].do_cfg) begin
        write_cutoff(apcm_pkg::CUT_W'(dir_tab[i].cut));
      end else begin
        typed_n      = dir_tab[i].n_typed;
        typed_rec[0] = dir_tab[i].rec0;
        typed_rec[1] = dir_tab[i].rec1;
        send_pair(dir_tab[i].item);
      end
    end
    typed_n = -1;

    // Random phases: each a cutoff setting and an idling mix
    cut_plan[6] = $urandom_range(2, 20000);
    cut_plan[7] = -int'($urandom_range(1048576));
    for (int p = 0; p < 8; p++) begin
      write_cutoff(apcm_pkg::CUT_W'(cut_plan[p]));
      src_idle_pct   = idle_plan[p % 4][0];
      sink_stall_pct = idle_plan[p % 4][1];
      reach = (cut_plan[p] > 0) ? cut_plan[p] : 3000;
      for (int i = 0; i < PHASE_PAIRS; i++) send_pair(rand_pair(reach));
      // Close the frame so the next phase starts from clear counters
      b = rand_pair(reach);
      b.frame_end = 1'b1;
      send_pair(b);
    end

    settle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
